>>> src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // request codes carried on req_tuser
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_DUMP       = 3'd4
   } func_type;

   // result status carried on rsp_tuser
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // control sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_DUMP
   } state_type;

endpackage

`default_nettype wire

>>> src/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram
   import deq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values kept in a ring store.
// ----------------------------------------------------------------------------
//  channel | dir | tdata       | tuser      | tlast
//  req_    | in  | value[31:0] | func[2:0]  | -
//  rsp_    | out | data_out    | status     | last
//
//  Push, a pop or dump on an empty queue and unused codes finish in ST_IDLE,
//  so such requests are taken every cycle while the result slot is free.
//  A pop that returns a value passes through ST_POP, which loads the registered store read.
//  Dump walks the entries front to back in ST_DUMP, one store read per beat.
//  Reset clears state, pointers, count, walk and output valid; the store needs no clearing pass.
//  A stalled result holds the sequencer; req_tready drops until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [VALUE_W-1:0]  req_tdata,   // [31:0] value
   input  wire logic [FUNC_W-1:0]   req_tuser,   // [2:0] func
   // result channel
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [VALUE_W-1:0]  rsp_tdata,   // [31:0] data_out
   output logic      [STATUS_W-1:0] rsp_tuser,   // [1:0] status
   output logic                     rsp_tlast
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW:0]   DEPTH_W = (IW+1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

   // ring slot that lies off places behind base
   function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
      logic [IW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[IW-1:0];
   endfunction

   state_type     state_ff, state_in;
   logic [IW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] walk_ff, walk_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic          ram_we, ram_re;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;

   logic          rsp_free, req_fire, is_empty, is_full, walk_done;
   func_type      func;
   logic          load;
   status_type    load_status;
   logic [VALUE_W-1:0] load_data;
   logic          load_last;
   logic [IW-1:0] front_dec;

   assign func      = func_type'(req_tuser);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req_tvalid && req_tready;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == DEPTH_C);
   assign walk_done = (walk_ff == count_ff);
   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - IW'(1);

   // entry store
   deq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (VALUE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_tdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !is_empty) begin
               if (func == FUNC_POP_FRONT || func == FUNC_POP_BACK) begin
                  state_in = ST_POP;
               end else if (func == FUNC_DUMP) begin
                  state_in = ST_DUMP;
               end
            end
         end
         ST_POP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (rsp_free && walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // pointer updates, store access and result loads
   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      walk_in     = walk_ff;
      ram_we      = 1'b0;
      ram_waddr   = front_ff;
      ram_re      = 1'b0;
      ram_raddr   = front_ff;
      load        = 1'b0;
      load_status = STATUS_OK;
      load_data   = '0;
      load_last   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (func)
                  FUNC_PUSH_FRONT: begin
                     load = 1'b1;
                     if (is_full) begin
                        load_status = STATUS_FULL;
                     end else begin
                        front_in  = front_dec;
                        ram_we    = 1'b1;
                        ram_waddr = front_dec;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  FUNC_PUSH_BACK: begin
                     load = 1'b1;
                     if (is_full) begin
                        load_status = STATUS_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_at(front_ff, count_ff[IW-1:0]);
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  FUNC_POP_FRONT: begin
                     if (is_empty) begin
                        load        = 1'b1;
                        load_status = STATUS_EMPTY;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = front_ff;
                        front_in  = slot_at(front_ff, IW'(1));
                        count_in  = count_ff - CW'(1);
                     end
                  end
                  FUNC_POP_BACK: begin
                     if (is_empty) begin
                        load        = 1'b1;
                        load_status = STATUS_EMPTY;
                     end else begin
                        count_in  = count_ff - CW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = slot_at(front_ff, count_in[IW-1:0]);
                     end
                  end
                  FUNC_DUMP: begin
                     if (is_empty) begin
                        load        = 1'b1;
                        load_status = STATUS_EMPTY;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = front_ff;
                        walk_in   = CW'(1);
                     end
                  end
                  default: ;  // unused codes are dropped
               endcase
            end
         end
         ST_POP: begin
            if (rsp_free) begin
               load      = 1'b1;
               load_data = ram_rdata;
            end
         end
         ST_DUMP: begin
            if (rsp_free) begin
               load      = 1'b1;
               load_data = ram_rdata;
               load_last = walk_done;
               if (!walk_done) begin
                  ram_re    = 1'b1;
                  ram_raddr = slot_at(front_ff, walk_ff[IW-1:0]);
                  walk_in   = walk_ff + CW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = load_status;
         rsp_data_in   = load_data;
         rsp_last_in   = load_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> !rsp_valid_ff)
      else $error("pop data arrived with output slot occupied");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_full &&
      (func == FUNC_PUSH_FRONT || func == FUNC_PUSH_BACK)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted push did not grow the queue");

   a_dump_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> walk_ff <= count_ff && walk_ff != '0)
      else $error("dump walk out of range");

endmodule

`default_nettype wire
